@@ sv/ria_pkg.sv @@
// Package for the rotating identifier allocator.
// Holds field widths, operation and status codes, and the storage request type.
// Used by ria_store and rotating_id_allocator_top; depends on nothing.
package ria_pkg;

  localparam int ID_SPACE_DEF = 1024;
  localparam int ID_W         = 10;
  localparam int KIND_W       = 4;
  localparam int NUM_W        = 8;
  localparam int OWNER_W      = KIND_W + NUM_W;
  localparam int STATUS_W     = 2;

  localparam logic [ID_W-1:0] MAX_ID_RESET = 10'd1023;

  localparam logic OP_ISSUE   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NONE_FREE  = 2'd1,
    STAT_NOT_IN_USE = 2'd2
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic wr_used;
    logic used_val;
    logic wr_owner;
  } store_req_t;

endpackage

@@ sv/ria_store.sv @@
// Storage for the allocator: the used map and the owner store.
// Single address port, one read or write of each memory per cycle, registered read.
// Depends on ria_pkg.
module ria_store
  import ria_pkg::*;
#(
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic                        clk,
  input  store_req_t                  req,
  input  logic [$clog2(ID_SPACE)-1:0] addr,
  input  logic [OWNER_W-1:0]          owner_wdata,
  output logic                        rd_data
);

  logic                used_mem  [ID_SPACE];
  logic [OWNER_W-1:0]  owner_mem [ID_SPACE];

  always_ff @(posedge clk) begin
    if (req.wr_used) begin
      used_mem[addr] <= req.used_val;
    end
    if (req.rd_en) begin
      rd_data <= used_mem[addr];
    end
  end

  // Owner data is kept with each issued identifier; nothing in this block reads it back.
  always_ff @(posedge clk) begin
    if (req.wr_owner) begin
      owner_mem[addr] <= owner_wdata;
    end
  end

endmodule

@@ sv/rotating_id_allocator_top.sv @@
// Top level of the rotating identifier allocator: sequencer, config register, result port.
// Instantiates ria_store; depends on ria_pkg.
//
// Usage:
//   An item is accepted at a rising edge with start high and busy low. operation selects
//   issue or release; worker_kind and worker_number are stored with an issued identifier,
//   release_id names the identifier to free.
//   Each item gives one result: done is high for exactly one cycle while status and
//   issued_id hold it. The receiver cannot stall the result port.
//   Issue walks the used map one identifier at a time, reading (ST_ISS_RD) then checking
//   (ST_ISS_CHK) each, from the next-candidate pointer, wrapping from max_id to 1, through
//   the single port of the used-map memory. A full map gives STAT_NONE_FREE once every
//   identifier from 1 to max_id has been read. Release reads the entry, then checks it.
//   busy drops in the cycle done is shown, so the next item can be accepted while the
//   result is shown.
//   The user must write max_id via cfg_wr_en/cfg_wr_data only when idle; not enforced.
//   Reset (rst, synchronous) sets max_id to 1023 and the pointer to 1, then clears the
//   used map one entry a cycle; busy stays high until the clear pass is done.
module rotating_id_allocator_top
  import ria_pkg::*;
#(
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                operation,
  input  logic [KIND_W-1:0]   worker_kind,
  input  logic [NUM_W-1:0]    worker_number,
  input  logic [ID_W-1:0]     release_id,
  input  logic                cfg_wr_en,
  input  logic [ID_W-1:0]     cfg_wr_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     issued_id
);

  localparam int IDW = $clog2(ID_SPACE);
  localparam int MW  = (IDW > ID_W) ? IDW : ID_W;
  localparam logic [MW-1:0]  TOP_ID  = MW'(ID_SPACE - 1);
  localparam logic [IDW-1:0] LAST_IX = IDW'(ID_SPACE - 1);
  localparam logic [IDW-1:0] ONE     = IDW'(1);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_ISS_RD  = 6'b000100,
    ST_ISS_CHK = 6'b001000,
    ST_REL_RD  = 6'b010000,
    ST_REL_CHK = 6'b100000
  } state_t;

  state_t             state, state_next;
  logic [ID_W-1:0]    max_id;
  logic [IDW-1:0]     next_candidate, next_candidate_next;
  logic [IDW-1:0]     cand, cand_next;
  logic [IDW-1:0]     scan_count, scan_count_next;
  logic [OWNER_W-1:0] owner_data;
  logic [IDW-1:0]     rel_addr;
  logic               rel_ok;

  logic               done_next;
  status_t            status_next;
  logic [ID_W-1:0]    issued_id_next;

  logic [MW-1:0]      max_ext;
  logic [IDW-1:0]     eff_max;
  logic [IDW-1:0]     cand_wrap;
  logic               accept;

  store_req_t         req;
  logic [IDW-1:0]     mem_addr;
  logic               rd_data;

  // A zero max_id acts as one; a max_id past the identifier space is clamped to its top.
  assign max_ext   = (max_id == '0) ? MW'(1) : MW'(max_id);
  assign eff_max   = (max_ext > TOP_ID) ? IDW'(TOP_ID) : IDW'(max_ext);
  assign cand_wrap = (cand == eff_max) ? ONE : cand + ONE;
  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign mem_addr  = (state == ST_REL_RD || state == ST_REL_CHK) ? rel_addr : cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_id <= MAX_ID_RESET;
    end else if (cfg_wr_en) begin
      max_id <= cfg_wr_data;
    end
  end

  always_comb begin
    state_next          = state;
    next_candidate_next = next_candidate;
    cand_next           = cand;
    scan_count_next     = scan_count;
    done_next           = 1'b0;
    status_next         = STAT_OK;
    issued_id_next      = '0;
    req                 = '0;
    case (state)
      ST_CLEAR: begin
        // The clear pass uses the candidate register as its address counter.
        req.wr_used = 1'b1;
        req.used_val = 1'b0;
        if (cand == LAST_IX) begin
          state_next = ST_IDLE;
        end else begin
          cand_next = cand + ONE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_ISSUE) begin
            // A pointer left out of range by a lowered max_id restarts the scan at one.
            cand_next = (next_candidate == '0 || next_candidate > eff_max) ?
                        ONE : next_candidate;
            scan_count_next = '0;
            state_next = ST_ISS_RD;
          end else begin
            state_next = ST_REL_RD;
          end
        end
      end
      ST_ISS_RD: begin
        req.rd_en = 1'b1;
        state_next = ST_ISS_CHK;
      end
      ST_ISS_CHK: begin
        if (!rd_data) begin
          req.wr_used = 1'b1;
          req.used_val = 1'b1;
          req.wr_owner = 1'b1;
          next_candidate_next = cand_wrap;
          done_next = 1'b1;
          status_next = STAT_OK;
          issued_id_next = ID_W'(cand);
          state_next = ST_IDLE;
        end else if (scan_count == eff_max - ONE) begin
          done_next = 1'b1;
          status_next = STAT_NONE_FREE;
          state_next = ST_IDLE;
        end else begin
          cand_next = cand_wrap;
          scan_count_next = scan_count + ONE;
          state_next = ST_ISS_RD;
        end
      end
      ST_REL_RD: begin
        req.rd_en = 1'b1;
        state_next = ST_REL_CHK;
      end
      ST_REL_CHK: begin
        done_next = 1'b1;
        state_next = ST_IDLE;
        if (rel_ok && rd_data) begin
          req.wr_used = 1'b1;
          req.used_val = 1'b0;
          status_next = STAT_OK;
        end else begin
          status_next = STAT_NOT_IN_USE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      next_candidate <= ONE;
      cand           <= '0;
      scan_count     <= '0;
      done           <= 1'b0;
    end else begin
      state          <= state_next;
      next_candidate <= next_candidate_next;
      cand           <= cand_next;
      scan_count     <= scan_count_next;
      done           <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    issued_id <= issued_id_next;
    if (accept) begin
      owner_data <= {worker_kind, worker_number};
      rel_addr   <= IDW'(release_id);
      rel_ok     <= (MW'(release_id) <= TOP_ID);
    end
  end

  ria_store #(
    .ID_SPACE (ID_SPACE)
  ) u_store (
    .clk         (clk),
    .req         (req),
    .addr        (mem_addr),
    .owner_wdata (owner_data),
    .rd_data     (rd_data)
  );

  a_done_in_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result shown while the sequencer is not idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_none_free_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_NONE_FREE |-> issued_id == '0)
    else $error("identifier reported while none was free");

  a_pointer_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_candidate != '0)
    else $error("next-candidate pointer reached zero");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

endmodule
